[hw/rtl/rppm_pkg.sv]
// Shared types, widths and codes for the ripple peak-to-peak meter.
// Used by every module of the block; depends on nothing.
package rppm_pkg;

  // Field widths.
  localparam int CODE_W     = 18;  // converter code, two's complement
  localparam int Q_W        = 32;  // Q16.16 values
  localparam int GAIN_W     = 24;  // unsigned Q4.20 gains
  localparam int NS_W       = 13;  // num_samples register
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Scaling arithmetic: code * range fits 22 bits, times gain fits 47 bits.
  localparam int CR_W     = 22;
  localparam int PROD_W   = CR_W + GAIN_W + 1;
  localparam int ROUND_SH = 21;

  // Percent arithmetic: diff * (100 / 2) * 2^16 over dc.
  localparam int DIFF_W    = Q_W + 1;
  localparam int PERCENT   = 100;
  localparam int HALF      = 2;
  localparam int PCT_MUL   = PERCENT / HALF;
  localparam int PCT_MUL_W = 6;
  localparam int FRAC_SH   = 16;
  localparam int NUM_W     = DIFF_W + PCT_MUL_W + FRAC_SH;

  // Reset values.
  localparam logic [GAIN_W-1:0] GAIN_ONE        = 24'h100000;
  localparam logic [NS_W-1:0]   NUM_SAMPLES_RST = 13'd2560;
  localparam int                MAX_SAMPLES_DEF = 4096;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_VA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_VB     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CB     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CC     = 3'd5;

  // Operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  // Gear codes.
  localparam logic       VGEAR_A = 1'b0;
  localparam logic       VGEAR_B = 1'b1;
  localparam logic [1:0] CGEAR_A = 2'd0;
  localparam logic [1:0] CGEAR_B = 2'd1;

  // Channel select for the shared divider.
  localparam logic CH_VOLT = 1'b0;
  localparam logic CH_CURR = 1'b1;

  typedef struct packed {
    logic clr_ext;    // clear max and min of both channels
    logic ld_smp;     // latch codes times range and the gains in use
    logic mul;        // form the gain products
    logic track;      // round and update the extremes
    logic ld_dc;      // latch the dc values of the finishing beat
    logic div_start;  // start the divider on the selected channel
    logic div_sel;    // channel the divider works for
    logic pct_ld;     // store the divider result for the selected channel
    logic out_ld;     // load the result register
  } rppm_cmd_t;

  typedef struct packed {
    logic div_done;
  } rppm_sts_t;

endpackage

[hw/rtl/ripple_peak_to_peak_meter_core.sv]
// Top level of the ripple peak-to-peak meter.
// Depends on rppm_pkg, rppm_ctrl and rppm_dp (which holds rppm_div).
//
// Usage:
//   Input beats arrive on in_valid / in_stall with one port per field. A beat
//   with in_operation set is a start and rearms the capture. While armed, the
//   first sample beat of a capture clears the extremes, the next num_samples
//   beats (at most MAX_SAMPLES) are scaled and tracked, and the beat after
//   those finishes the capture with its dc values, produces one result beat
//   and disarms. A sample beat arriving while disarmed is dropped without a result.
// Sequencing:
//   Start, dropped and clearing beats leave the block idle, ready for the next
//   beat. A tracked sample passes through latch, gain multiply, and round and
//   compare; the extremes update is what the next sample depends on. A
//   finishing beat latches its dc values, takes two passes of the bit-serial
//   divider, one per channel, then loads the result and raises out_valid.
// Output and stall:
//   The result sits in an output register, so new input beats are taken while
//   it waits. Only a second finishing beat waits for out_stall to release.
// Reset:
//   rst_n is synchronous, active low. It arms the block, clears the tick count
//   and extremes, and restores num_samples to 2560 and every gain to 1.0.
module ripple_peak_to_peak_meter_core #(
  parameter int MAX_SAMPLES = rppm_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic signed [rppm_pkg::CODE_W-1:0]    in_volt_code,
  input  logic signed [rppm_pkg::CODE_W-1:0]    in_curr_code,
  input  logic                                  in_volt_gear,
  input  logic [1:0]                            in_curr_gear,
  input  logic                                  in_range_ten_volt,
  input  logic signed [rppm_pkg::Q_W-1:0]       in_dc_voltage,
  input  logic signed [rppm_pkg::Q_W-1:0]       in_dc_current,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rppm_pkg::Q_W-1:0]              out_volt_ripple_amp,
  output logic [rppm_pkg::Q_W-1:0]              out_curr_ripple_amp,
  output logic signed [rppm_pkg::Q_W-1:0]       out_volt_ripple_percent,
  output logic signed [rppm_pkg::Q_W-1:0]       out_curr_ripple_percent,
  output logic                                  out_volt_dc_zero,
  output logic                                  out_curr_dc_zero,

  input  logic                                  cfg_wr_en,
  input  logic [rppm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rppm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // The controller owns the capture sequencing state; the datapath executes the
  // command bundle it gets each cycle and reports when its divider is done.
  rppm_pkg::rppm_cmd_t cmd;
  rppm_pkg::rppm_sts_t sts;

  rppm_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_operation    (in_operation),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_num_samples (cfg_data[rppm_pkg::NS_W-1:0]),
    .cmd             (cmd),
    .sts             (sts)
  );

  // Scaling, extremes tracking, the shared divider and the result register.
  rppm_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_volt_code            (in_volt_code),
    .in_curr_code            (in_curr_code),
    .in_volt_gear            (in_volt_gear),
    .in_curr_gear            (in_curr_gear),
    .in_range_ten_volt       (in_range_ten_volt),
    .in_dc_voltage           (in_dc_voltage),
    .in_dc_current           (in_dc_current),
    .out_volt_ripple_amp     (out_volt_ripple_amp),
    .out_curr_ripple_amp     (out_curr_ripple_amp),
    .out_volt_ripple_percent (out_volt_ripple_percent),
    .out_curr_ripple_percent (out_curr_ripple_percent),
    .out_volt_dc_zero        (out_volt_dc_zero),
    .out_curr_dc_zero        (out_curr_dc_zero)
  );

endmodule

[hw/rtl/rppm_div.sv]
// Bit-serial restoring divider for the ripple percent, one quotient bit a cycle.
// Depends on rppm_pkg for widths.
module rppm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rppm_pkg::NUM_W-1:0]         num,
  input  logic signed [rppm_pkg::Q_W-1:0]    den,
  output logic                               done,
  output logic signed [rppm_pkg::Q_W-1:0]    quo
);

  localparam int NUM_W  = rppm_pkg::NUM_W;
  localparam int Q_W    = rppm_pkg::Q_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam logic [NUM_W-1:0] POS_LIM = {{(NUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic [NUM_W-1:0] NEG_LIM = POS_LIM + NUM_W'(1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [Q_W-1:0]    rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [Q_W-1:0]    dmag_r;
  logic              neg_r;

  logic [Q_W:0]      sh;
  logic [Q_W:0]      dif;
  logic              fit;
  logic [Q_W-1:0]    rem_nxt;
  logic [Q_W-1:0]    den_mag;

  assign den_mag = den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
  assign sh      = {rem_r, quo_r[NUM_W-1]};
  assign dif     = sh - {1'b0, dmag_r};
  assign fit     = sh >= {1'b0, dmag_r};
  assign rem_nxt = fit ? dif[Q_W-1:0] : sh[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= num;
      dmag_r <= den_mag;
      neg_r  <= den[Q_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], fit};
    end
  end

  // The numerator is never negative, so the sign comes from the divisor alone.
  always_comb begin
    if (neg_r) begin
      quo = (quo_r > NEG_LIM) ? {1'b1, {(Q_W-1){1'b0}}} : Q_W'(-quo_r[Q_W-1:0]);
    end else begin
      quo = (quo_r > POS_LIM) ? {1'b0, {(Q_W-1){1'b1}}} : quo_r[Q_W-1:0];
    end
  end

  assign done = done_r;

endmodule

[hw/rtl/rppm_dp.sv]
// Datapath of the ripple meter: gain registers, scaling, extremes, divider, result register.
// Depends on rppm_pkg and rppm_div; driven by rppm_ctrl through rppm_cmd_t.
module rppm_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [rppm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rppm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  rppm_pkg::rppm_cmd_t                   cmd,
  output rppm_pkg::rppm_sts_t                   sts,
  input  logic signed [rppm_pkg::CODE_W-1:0]    in_volt_code,
  input  logic signed [rppm_pkg::CODE_W-1:0]    in_curr_code,
  input  logic                                  in_volt_gear,
  input  logic [1:0]                            in_curr_gear,
  input  logic                                  in_range_ten_volt,
  input  logic signed [rppm_pkg::Q_W-1:0]       in_dc_voltage,
  input  logic signed [rppm_pkg::Q_W-1:0]       in_dc_current,
  output logic [rppm_pkg::Q_W-1:0]              out_volt_ripple_amp,
  output logic [rppm_pkg::Q_W-1:0]              out_curr_ripple_amp,
  output logic signed [rppm_pkg::Q_W-1:0]       out_volt_ripple_percent,
  output logic signed [rppm_pkg::Q_W-1:0]       out_curr_ripple_percent,
  output logic                                  out_volt_dc_zero,
  output logic                                  out_curr_dc_zero
);

  localparam int Q_W      = rppm_pkg::Q_W;
  localparam int GAIN_W   = rppm_pkg::GAIN_W;
  localparam int CR_W     = rppm_pkg::CR_W;
  localparam int PROD_W   = rppm_pkg::PROD_W;
  localparam int DIFF_W   = rppm_pkg::DIFF_W;
  localparam int NUM_W    = rppm_pkg::NUM_W;
  localparam int ROUND_SH = rppm_pkg::ROUND_SH;

  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (ROUND_SH - 1);

  function automatic logic signed [CR_W-1:0] range_mul(
    input logic signed [rppm_pkg::CODE_W-1:0] c,
    input logic                               ten
  );
    logic signed [CR_W-1:0] x;
    x = CR_W'(c);
    return ten ? (x <<< 3) + (x <<< 1) : (x <<< 2) + x;
  endfunction

  logic [GAIN_W-1:0] gain_va_r, gain_vb_r, gain_ca_r, gain_cb_r, gain_cc_r;

  logic signed [CR_W-1:0]   cr_v_r, cr_c_r;
  logic [GAIN_W-1:0]        g_v_r, g_c_r;
  logic signed [PROD_W-1:0] p_v_r, p_c_r;
  logic signed [Q_W-1:0]    max_v_r, min_v_r, max_c_r, min_c_r;
  logic signed [Q_W-1:0]    dc_v_r, dc_c_r;
  logic                     zero_v_r, zero_c_r;
  logic signed [Q_W-1:0]    pct_v_r, pct_c_r;

  logic [GAIN_W-1:0]        g_c_sel;
  logic signed [PROD_W-1:0] sum_v, sum_c, shv, shc;
  logic signed [Q_W-1:0]    s_v, s_c;
  logic [DIFF_W-1:0]        diff_v, diff_c, diff_sel;
  logic [NUM_W-1:0]         div_num;
  logic signed [Q_W-1:0]    div_den;
  logic signed [Q_W-1:0]    div_quo;
  logic                     div_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_va_r <= rppm_pkg::GAIN_ONE;
      gain_vb_r <= rppm_pkg::GAIN_ONE;
      gain_ca_r <= rppm_pkg::GAIN_ONE;
      gain_cb_r <= rppm_pkg::GAIN_ONE;
      gain_cc_r <= rppm_pkg::GAIN_ONE;
    end else if (cfg_wr_en) begin
      if (cfg_index == rppm_pkg::CFG_GAIN_VA) gain_va_r <= cfg_data[GAIN_W-1:0];
      if (cfg_index == rppm_pkg::CFG_GAIN_VB) gain_vb_r <= cfg_data[GAIN_W-1:0];
      if (cfg_index == rppm_pkg::CFG_GAIN_CA) gain_ca_r <= cfg_data[GAIN_W-1:0];
      if (cfg_index == rppm_pkg::CFG_GAIN_CB) gain_cb_r <= cfg_data[GAIN_W-1:0];
      if (cfg_index == rppm_pkg::CFG_GAIN_CC) gain_cc_r <= cfg_data[GAIN_W-1:0];
    end
  end

  // Current gear codes two and three both use gear C.
  always_comb begin
    unique case (in_curr_gear)
      rppm_pkg::CGEAR_A: g_c_sel = gain_ca_r;
      rppm_pkg::CGEAR_B: g_c_sel = gain_cb_r;
      default:           g_c_sel = gain_cc_r;
    endcase
  end

  // Scaling pipeline: latch, multiply, round.
  always_ff @(posedge clk) begin
    if (cmd.ld_smp) begin
      cr_v_r <= range_mul(in_volt_code, in_range_ten_volt);
      cr_c_r <= range_mul(in_curr_code, in_range_ten_volt);
      g_v_r  <= (in_volt_gear == rppm_pkg::VGEAR_B) ? gain_vb_r : gain_va_r;
      g_c_r  <= g_c_sel;
    end
    if (cmd.mul) begin
      p_v_r <= PROD_W'(cr_v_r) * PROD_W'($signed({1'b0, g_v_r}));
      p_c_r <= PROD_W'(cr_c_r) * PROD_W'($signed({1'b0, g_c_r}));
    end
  end

  // Adding half an LSB and shifting arithmetically rounds half up in both signs.
  assign sum_v = p_v_r + RND;
  assign sum_c = p_c_r + RND;
  assign shv   = sum_v >>> ROUND_SH;
  assign shc   = sum_c >>> ROUND_SH;
  assign s_v   = shv[Q_W-1:0];
  assign s_c   = shc[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_ext) begin
      max_v_r <= '0;
      min_v_r <= '0;
      max_c_r <= '0;
      min_c_r <= '0;
    end else if (cmd.track) begin
      if (s_v > max_v_r) max_v_r <= s_v;
      else if (s_v < min_v_r) min_v_r <= s_v;
      if (s_c > max_c_r) max_c_r <= s_c;
      else if (s_c < min_c_r) min_c_r <= s_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_dc) begin
      dc_v_r   <= in_dc_voltage;
      dc_c_r   <= in_dc_current;
      zero_v_r <= (in_dc_voltage == '0);
      zero_c_r <= (in_dc_current == '0);
    end
  end

  // Max never drops below zero and min never rises above it, so the difference is not negative.
  assign diff_v   = DIFF_W'(max_v_r) - DIFF_W'(min_v_r);
  assign diff_c   = DIFF_W'(max_c_r) - DIFF_W'(min_c_r);
  assign diff_sel = (cmd.div_sel == rppm_pkg::CH_CURR) ? diff_c : diff_v;
  assign div_num  = (NUM_W'(diff_sel) * NUM_W'(rppm_pkg::PCT_MUL)) << rppm_pkg::FRAC_SH;
  assign div_den  = (cmd.div_sel == rppm_pkg::CH_CURR) ? dc_c_r : dc_v_r;

  rppm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.pct_ld) begin
      if (cmd.div_sel == rppm_pkg::CH_CURR) pct_c_r <= zero_c_r ? '0 : div_quo;
      else pct_v_r <= zero_v_r ? '0 : div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_volt_ripple_amp     <= diff_v[DIFF_W-1:1];
      out_curr_ripple_amp     <= diff_c[DIFF_W-1:1];
      out_volt_ripple_percent <= pct_v_r;
      out_curr_ripple_percent <= pct_c_r;
      out_volt_dc_zero        <= zero_v_r;
      out_curr_dc_zero        <= zero_c_r;
    end
  end

endmodule

[hw/rtl/rppm_ctrl.sv]
// Controller of the ripple meter: capture sequencing, tick count, arming and result valid.
// Depends on rppm_pkg; commands rppm_dp through rppm_cmd_t.
module rppm_ctrl #(
  parameter int MAX_SAMPLES = rppm_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_operation,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           cfg_wr_en,
  input  logic [rppm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rppm_pkg::NS_W-1:0]      cfg_num_samples,
  output rppm_pkg::rppm_cmd_t            cmd,
  input  rppm_pkg::rppm_sts_t            sts
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 2);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_TRACK  = 3'd2;
  localparam logic [2:0] ST_DIV_V  = 3'd3;
  localparam logic [2:0] ST_WAIT_V = 3'd4;
  localparam logic [2:0] ST_DIV_C  = 3'd5;
  localparam logic [2:0] ST_WAIT_C = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         tick_count_r, tick_count_nxt;
  logic                     armed_r, armed_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [rppm_pkg::NS_W-1:0] num_samples_r;
  logic [CNT_W-1:0]         n_eff;
  logic                     accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_samples_r <= rppm_pkg::NUM_SAMPLES_RST;
    end else if (cfg_wr_en && cfg_index == rppm_pkg::CFG_NUM_SAMPLES) begin
      num_samples_r <= cfg_num_samples;
    end
  end

  assign n_eff = (32'(num_samples_r) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                        : CNT_W'(num_samples_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    tick_count_nxt = tick_count_r;
    armed_nxt      = armed_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_operation == rppm_pkg::OP_START) begin
            armed_nxt = 1'b1;
          end else if (!armed_r) begin
            armed_nxt = 1'b0;
          end else if (tick_count_r == '0) begin
            cmd.clr_ext    = 1'b1;
            tick_count_nxt = CNT_W'(1);
          end else if (tick_count_r <= n_eff) begin
            cmd.ld_smp     = 1'b1;
            tick_count_nxt = tick_count_r + CNT_W'(1);
            state_nxt      = ST_MUL;
          end else begin
            cmd.ld_dc      = 1'b1;
            tick_count_nxt = '0;
            armed_nxt      = 1'b0;
            state_nxt      = ST_DIV_V;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_TRACK;
      end
      ST_TRACK: begin
        cmd.track = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DIV_V: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rppm_pkg::CH_VOLT;
        state_nxt     = ST_WAIT_V;
      end
      ST_WAIT_V: begin
        cmd.div_sel = rppm_pkg::CH_VOLT;
        if (sts.div_done) begin
          cmd.pct_ld = 1'b1;
          state_nxt  = ST_DIV_C;
        end
      end
      ST_DIV_C: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rppm_pkg::CH_CURR;
        state_nxt     = ST_WAIT_C;
      end
      ST_WAIT_C: begin
        cmd.div_sel = rppm_pkg::CH_CURR;
        if (sts.div_done) begin
          cmd.pct_ld = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_count_r <= '0;
      armed_r      <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      armed_r      <= armed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  a_finish_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == rppm_pkg::OP_SAMPLE && armed_r &&
     tick_count_r != '0 && tick_count_r > n_eff)
    |=> (!armed_r && tick_count_r == '0 && state_r == ST_DIV_V))
    else $error("finishing beat did not disarm and start the division");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_WAIT_V || state_r == ST_WAIT_C))
    else $error("divider finished outside a wait state");

  a_free_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("free result register was not loaded");

endmodule
